// File: src/h264_fua_pkg.sv
package h264_fua_pkg;

  // Field widths fixed by the stream format
  localparam int BYTE_W    = 8;
  localparam int NLEN_W    = 16;
  localparam int MAXPAY_W  = 11;
  localparam int TSSTEP_W  = 17;
  localparam int SEQ_W     = 16;
  localparam int TS_W      = 32;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  // Configuration register map (word index = paddr[2])
  typedef enum logic {
    REG_MAX_PAYLOAD = 1'b0,
    REG_TS_STEP     = 1'b1
  } reg_idx_t;

  localparam logic [MAXPAY_W-1:0] MAX_PAYLOAD_RST = 11'd1400;
  localparam logic [TSSTEP_W-1:0] TS_STEP_RST     = 17'd3000;

  // NAL / FU-A header fields
  localparam logic [BYTE_W-1:0] NAL_TYPE_MASK = 8'h1F;
  localparam logic [BYTE_W-1:0] NAL_NRI_MASK  = 8'h60;
  localparam logic [BYTE_W-1:0] FU_A_TYPE     = 8'd28;
  localparam logic [BYTE_W-1:0] FU_START_BIT  = 8'h80;
  localparam logic [BYTE_W-1:0] FU_END_BIT    = 8'h40;
  localparam logic [4:0]        NAL_TYPE_SPS  = 5'd7;
  localparam logic [4:0]        NAL_TYPE_PPS  = 5'd8;

  // Input item: one NAL byte
  typedef struct packed {
    logic [BYTE_W-1:0] nal_byte;
    logic              nal_first;
    logic [NLEN_W-1:0] nal_length;
  } in_payload_t;

  // Result item: one packet byte
  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              packet_first;
    logic              packet_last;
    logic [SEQ_W-1:0]  seq_number;
    logic [TS_W-1:0]   time_stamp;
    logic              result_last;
  } out_payload_t;

  // One queued result byte with its packet marks
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              pkt_first;
    logic              pkt_last;
  } res_entry_t;

endpackage

// File: src/h264_fua_if.sv
// NAL byte stream channel
interface h264_fua_in_if;
  logic                      valid;
  logic                      ready;
  h264_fua_pkg::in_payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// Packet byte stream channel
interface h264_fua_out_if;
  logic                       valid;
  logic                       ready;
  h264_fua_pkg::out_payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: src/h264_fu_a_packetizer_top.sv
// H.264 RTP packetizer with FU-A fragmentation. NAL bytes enter one per transfer
// on in_ch, header byte first, with the NAL length on every byte; packet bytes
// leave on out_ch with first/last marks, sequence number and timestamp. Most
// input bytes produce one output byte, and the block takes one byte per clock
// when out_ch is not stalled. The first data byte of every FU-A fragment
// produces three bytes (FU indicator, FU header, data), so the input stalls
// there while they drain; the header byte of a fragmented NAL produces nothing.
// Rate is set by the three-entry result register, which drains one byte per
// cycle while out_ch is ready. Bytes pass the input register, then the result
// register. A two-entry skid on the input keeps in_ch.ready a register output.
// The user must write max_payload and ts_step (APB byte addresses 0 and 4)
// only while the block is idle; the block itself does not enforce this.
module h264_fu_a_packetizer_top #(
  parameter int LEN_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  h264_fua_in_if.sink                             in_ch,
  h264_fua_out_if.source                          out_ch,
  input  logic                                    cfg_psel,
  input  logic                                    cfg_penable,
  input  logic                                    cfg_pwrite,
  input  logic [h264_fua_pkg::CFG_AW-1:0]         cfg_paddr,
  input  logic [h264_fua_pkg::CFG_DW-1:0]         cfg_pwdata,
  output logic [h264_fua_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                                    cfg_pready
);

  localparam int LW = LEN_BITS;
  // length bits actually carried by the input field
  localparam int UB = (LEN_BITS < h264_fua_pkg::NLEN_W) ? LEN_BITS : h264_fua_pkg::NLEN_W;
  localparam int MW = h264_fua_pkg::MAXPAY_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [MW-1:0]                         max_pay_r;
  logic [h264_fua_pkg::TSSTEP_W-1:0]     ts_step_r;
  logic                                  cfg_wr;
  h264_fua_pkg::reg_idx_t                cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = h264_fua_pkg::reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pay_r <= h264_fua_pkg::MAX_PAYLOAD_RST;
      ts_step_r <= h264_fua_pkg::TS_STEP_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        h264_fua_pkg::REG_MAX_PAYLOAD: max_pay_r <= cfg_pwdata[MW-1:0];
        h264_fua_pkg::REG_TS_STEP:     ts_step_r <= cfg_pwdata[h264_fua_pkg::TSSTEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      h264_fua_pkg::REG_MAX_PAYLOAD:
        cfg_prdata = h264_fua_pkg::CFG_DW'(max_pay_r);
      h264_fua_pkg::REG_TS_STEP:
        cfg_prdata = h264_fua_pkg::CFG_DW'(ts_step_r);
      default: cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register with skid entry
  h264_fua_pkg::in_payload_t main_r, skid_r;
  logic                      main_v_r, skid_v_r;
  logic                      in_xfer;
  logic                      proc;       // main entry handed to the packetizer
  logic                      bundle_free;
  logic [1:0]                rem_r;      // result bytes still queued

  assign in_ch.ready = !skid_v_r;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign bundle_free = (rem_r == 2'd0) || (rem_r == 2'd1 && out_ch.ready);
  assign proc        = main_v_r && bundle_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (proc) begin
      if (skid_v_r) begin
        main_r   <= skid_r;
        skid_v_r <= 1'b0;
      end else if (in_xfer) begin
        main_r   <= in_ch.payload;
      end else begin
        main_v_r <= 1'b0;
      end
    end else if (in_xfer) begin
      if (main_v_r) begin
        skid_r   <= in_ch.payload;
        skid_v_r <= 1'b1;
      end else begin
        main_r   <= in_ch.payload;
        main_v_r <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Packetizer state
  logic [LW-1:0]                      byte_cnt_r, byte_cnt_nxt;
  logic [MW-1:0]                      frag_fill_r, frag_fill_nxt;
  logic [h264_fua_pkg::BYTE_W-1:0]    header_r, header_nxt;
  logic                               frag_r, frag_nxt;
  logic [h264_fua_pkg::SEQ_W-1:0]     seq_cnt_r, seq_cnt_nxt;
  logic [h264_fua_pkg::TS_W-1:0]      ts_cnt_r, ts_cnt_nxt;

  // per-item decode
  logic [h264_fua_pkg::BYTE_W-1:0]    b;
  logic                               first;
  logic [LW-1:0]                      len_raw, len;
  logic [MW-1:0]                      mp;
  logic                               active;
  logic [LW-1:0]                      p;
  logic [MW-1:0]                      ff;
  logic [h264_fua_pkg::BYTE_W-1:0]    hb;
  logic                               frag;
  logic                               nal_end, pkt_end, last_frag;
  logic [LW-1:0]                      len_left;
  logic [h264_fua_pkg::BYTE_W-1:0]    fu_ind, fu_hdr;
  logic [4:0]                         nal_type;
  logic [1:0]                         n_res;
  h264_fua_pkg::res_entry_t           new_ent [3];

  always_comb begin
    b       = main_r.nal_byte;
    first   = main_r.nal_first;
    len_raw = LW'(main_r.nal_length[UB-1:0]);
    len     = (len_raw == '0) ? LW'(1) : len_raw;
    mp      = (max_pay_r == '0) ? MW'(1) : max_pay_r;
    active  = first || (byte_cnt_r != '0);
    p       = first ? '0 : byte_cnt_r;
    ff      = first ? '0 : frag_fill_r;
    hb      = first ? b : header_r;
    frag    = first ? (len > LW'(mp)) : frag_r;

    nal_end   = ({1'b0, p} + (LW+1)'(1)) >= {1'b0, len};
    len_left  = len - p;
    last_frag = (p >= len) || (len_left <= LW'(mp));
    nal_type  = hb[4:0];

    fu_ind = (hb & h264_fua_pkg::NAL_NRI_MASK) | h264_fua_pkg::FU_A_TYPE;
    fu_hdr = hb & h264_fua_pkg::NAL_TYPE_MASK;
    if (p == LW'(1)) fu_hdr = fu_hdr | h264_fua_pkg::FU_START_BIT;
    if (last_frag)   fu_hdr = fu_hdr | h264_fua_pkg::FU_END_BIT;

    pkt_end = 1'b0;
    n_res   = 2'd0;
    for (int i = 0; i < 3; i++) new_ent[i] = '0;

    if (!frag) begin
      // single-packet NAL: pass byte through
      pkt_end    = nal_end;
      n_res      = 2'd1;
      new_ent[0] = '{data: b, pkt_first: (p == '0), pkt_last: nal_end};
    end else if (p != '0) begin
      pkt_end = nal_end || (({1'b0, ff} + (MW+1)'(1)) >= {1'b0, mp});
      if (ff == '0) begin
        // fragment opens: indicator and FU header ahead of the data byte
        n_res      = 2'd3;
        new_ent[0] = '{data: fu_ind, pkt_first: 1'b1, pkt_last: 1'b0};
        new_ent[1] = '{data: fu_hdr, pkt_first: 1'b0, pkt_last: 1'b0};
        new_ent[2] = '{data: b,      pkt_first: 1'b0, pkt_last: pkt_end};
      end else begin
        n_res      = 2'd1;
        new_ent[0] = '{data: b, pkt_first: 1'b0, pkt_last: pkt_end};
      end
    end

    if (!active) begin
      // stray byte while idle
      pkt_end = 1'b0;
      n_res   = 2'd0;
    end
  end

  // state update for a processed item
  always_comb begin
    byte_cnt_nxt  = byte_cnt_r;
    frag_fill_nxt = frag_fill_r;
    header_nxt    = header_r;
    frag_nxt      = frag_r;
    seq_cnt_nxt   = seq_cnt_r;
    ts_cnt_nxt    = ts_cnt_r;
    if (proc && active) begin
      byte_cnt_nxt  = nal_end ? '0 : (p + LW'(1));
      frag_fill_nxt = ff;
      if (frag && p != '0) frag_fill_nxt = pkt_end ? '0 : (ff + MW'(1));
      header_nxt    = hb;
      frag_nxt      = frag;
      if (pkt_end) seq_cnt_nxt = seq_cnt_r + h264_fua_pkg::SEQ_W'(1);
      if (nal_end) begin
        if (frag || (nal_type != h264_fua_pkg::NAL_TYPE_SPS &&
                     nal_type != h264_fua_pkg::NAL_TYPE_PPS))
          ts_cnt_nxt = ts_cnt_r + h264_fua_pkg::TS_W'(ts_step_r);
        frag_nxt      = 1'b0;
        frag_fill_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r  <= '0;
      frag_fill_r <= '0;
      header_r    <= '0;
      frag_r      <= 1'b0;
      seq_cnt_r   <= '0;
      ts_cnt_r    <= '0;
    end else begin
      byte_cnt_r  <= byte_cnt_nxt;
      frag_fill_r <= frag_fill_nxt;
      header_r    <= header_nxt;
      frag_r      <= frag_nxt;
      seq_cnt_r   <= seq_cnt_nxt;
      ts_cnt_r    <= ts_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: up to three bytes, drained from entry 0
  h264_fua_pkg::res_entry_t           ent_r [3];
  logic [h264_fua_pkg::SEQ_W-1:0]     out_seq_r;
  logic [h264_fua_pkg::TS_W-1:0]      out_ts_r;
  logic                               out_xfer;

  assign out_xfer = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
    end else if (proc) begin
      rem_r <= n_res;
    end else if (out_xfer) begin
      rem_r <= rem_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      for (int i = 0; i < 3; i++) ent_r[i] <= new_ent[i];
      out_seq_r <= seq_cnt_r;
      out_ts_r  <= ts_cnt_r;
    end else if (out_xfer) begin
      ent_r[0] <= ent_r[1];
      ent_r[1] <= ent_r[2];
    end
  end

  assign out_ch.valid                = (rem_r != 2'd0);
  assign out_ch.payload.payload_byte = ent_r[0].data;
  assign out_ch.payload.packet_first = ent_r[0].pkt_first;
  assign out_ch.payload.packet_last  = ent_r[0].pkt_last;
  assign out_ch.payload.seq_number   = out_seq_r;
  assign out_ch.payload.time_stamp   = out_ts_r;
  assign out_ch.payload.result_last  = (rem_r == 2'd1);

  // ---------------------------------------------------------------------------
  // Assertions

  // input back-pressure only with both input entries occupied
  a_skid_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> main_v_r)
    else $error("skid entry held while main entry empty");

  // fragment fill only counts inside a fragmented NAL
  a_fill_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!frag_r || byte_cnt_r == '0) |-> frag_fill_r == '0)
    else $error("fragment fill left over outside a fragmented NAL");

  // each closed packet advances the sequence number by exactly one
  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && active && pkt_end) |=>
      seq_cnt_r == $past(seq_cnt_r) + h264_fua_pkg::SEQ_W'(1))
    else $error("sequence number did not advance on packet end");

endmodule

// File: tb/h264_fu_a_packetizer_top_tb.sv
module h264_fu_a_packetizer_top_tb;

  // Expected packet bytes, built from each accepted NAL byte
  class packet_scoreboard;
    logic [h264_fua_pkg::MAXPAY_W-1:0] max_payload;
    logic [h264_fua_pkg::TSSTEP_W-1:0] ts_step;
    logic [h264_fua_pkg::NLEN_W-1:0]   byte_count;
    logic [h264_fua_pkg::MAXPAY_W-1:0] frag_fill;
    logic [h264_fua_pkg::BYTE_W-1:0]   header_byte;
    bit                                fragmenting;
    logic [h264_fua_pkg::SEQ_W-1:0]    seq_counter;
    logic [h264_fua_pkg::TS_W-1:0]     ts_counter;
    h264_fua_pkg::out_payload_t        pending_pkt_bytes[$];
    int unsigned                       errors;

    function new();
      max_payload = h264_fua_pkg::MAX_PAYLOAD_RST;
      ts_step     = h264_fua_pkg::TS_STEP_RST;
      byte_count  = '0;
      frag_fill   = '0;
      header_byte = '0;
      fragmenting = 1'b0;
      seq_counter = '0;
      ts_counter  = '0;
      errors      = 0;
    endfunction

    function void set_reg(h264_fua_pkg::reg_idx_t idx,
                          logic [h264_fua_pkg::CFG_DW-1:0] val);
      if (idx == h264_fua_pkg::REG_MAX_PAYLOAD) begin
        max_payload = val[h264_fua_pkg::MAXPAY_W-1:0];
      end else begin
        ts_step = val[h264_fua_pkg::TSSTEP_W-1:0];
      end
    endfunction

    function h264_fua_pkg::out_payload_t pkt_byte(logic [h264_fua_pkg::BYTE_W-1:0] b,
                                                  bit pf, bit pl);
      h264_fua_pkg::out_payload_t r;
      r.payload_byte = b;
      r.packet_first = pf;
      r.packet_last  = pl;
      r.seq_number   = seq_counter;
      r.time_stamp   = ts_counter;
      r.result_last  = 1'b0;
      return r;
    endfunction

    // Packetize one NAL byte; returns 0 for a stray byte seen while idle
    function bit note_nal_byte(h264_fua_pkg::in_payload_t it);
      h264_fua_pkg::out_payload_t      res[3];
      int                              n;
      int unsigned                     len, mp, p;
      bit                              nal_end, pkt_end;
      logic [h264_fua_pkg::BYTE_W-1:0] hdr;
      n   = 0;
      len = it.nal_length;
      if (len == 0) len = 1;
      mp = (max_payload == 0) ? 1 : max_payload;
      if (it.nal_first) begin
        byte_count  = '0;
        frag_fill   = '0;
        header_byte = it.nal_byte;
        fragmenting = len > mp;
      end else if (byte_count == 0) begin
        return 1'b0;
      end
      p       = byte_count;
      nal_end = (p + 1 >= len);
      pkt_end = 1'b0;
      if (!fragmenting) begin
        pkt_end = nal_end;
        res[n]  = pkt_byte(it.nal_byte, p == 0, pkt_end);
        n++;
      end else if (p != 0) begin
        pkt_end = nal_end || (frag_fill + 1 >= mp);
        // fragment opens: FU indicator and FU header go first
        if (frag_fill == 0) begin
          hdr = header_byte & h264_fua_pkg::NAL_TYPE_MASK;
          if (p == 1) hdr = hdr | h264_fua_pkg::FU_START_BIT;
          if (p >= len || len - p <= mp) hdr = hdr | h264_fua_pkg::FU_END_BIT;
          res[n] = pkt_byte((header_byte & h264_fua_pkg::NAL_NRI_MASK) |
                            h264_fua_pkg::FU_A_TYPE, 1'b1, 1'b0);
          n++;
          res[n] = pkt_byte(hdr, 1'b0, 1'b0);
          n++;
        end
        res[n]    = pkt_byte(it.nal_byte, 1'b0, pkt_end);
        n++;
        frag_fill = pkt_end ? '0 : frag_fill + 1'b1;
      end
      byte_count = nal_end ? '0 : h264_fua_pkg::NLEN_W'(p + 1);
      if (pkt_end) seq_counter = seq_counter + 1'b1;
      if (nal_end) begin
        if (fragmenting || (header_byte[4:0] != h264_fua_pkg::NAL_TYPE_SPS &&
                            header_byte[4:0] != h264_fua_pkg::NAL_TYPE_PPS)) begin
          ts_counter = ts_counter + ts_step;
        end
        fragmenting = 1'b0;
        frag_fill   = '0;
      end
      if (n > 0) res[n-1].result_last = 1'b1;
      for (int i = 0; i < n; i++) pending_pkt_bytes.push_back(res[i]);
      return 1'b1;
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_packet_byte(h264_fua_pkg::out_payload_t got);
      h264_fua_pkg::out_payload_t want;
      if (pending_pkt_bytes.size() == 0) begin
        errors++;
        $display("%0t: packet byte with nothing expected, expected none, actual %h",
                 $time, got);
        return;
      end
      want = pending_pkt_bytes.pop_front();
      cmp_field("payload_byte", want.payload_byte, got.payload_byte);
      cmp_field("packet_first", want.packet_first, got.packet_first);
      cmp_field("packet_last", want.packet_last, got.packet_last);
      cmp_field("seq_number", want.seq_number, got.seq_number);
      cmp_field("time_stamp", want.time_stamp, got.time_stamp);
      cmp_field("result_last", want.result_last, got.result_last);
    endfunction

    function int pending();
      return pending_pkt_bytes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic                              cfg_psel;
  logic                              cfg_penable;
  logic                              cfg_pwrite;
  logic [h264_fua_pkg::CFG_AW-1:0]   cfg_paddr;
  logic [h264_fua_pkg::CFG_DW-1:0]   cfg_pwdata;
  logic [h264_fua_pkg::CFG_DW-1:0]   cfg_prdata;
  logic                              cfg_pready;

  h264_fua_in_if  in_ch();
  h264_fua_out_if out_ch();

  packet_scoreboard sb;
  bit               calm;
  int unsigned      items_sent;

  h264_fu_a_packetizer_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit
  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: check each transfer, stall at random
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      sb.check_packet_byte(out_ch.payload);
    end
    out_ch.ready <= calm || ($urandom_range(0, 99) >= 20);
  end

  // One NAL byte transfer, then maybe a gap
  task automatic send_item(logic [h264_fua_pkg::BYTE_W-1:0] b, logic f,
                           logic [h264_fua_pkg::NLEN_W-1:0] len);
    h264_fua_pkg::in_payload_t it;
    it.nal_byte   = b;
    it.nal_first  = f;
    it.nal_length = len;
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (sb.note_nal_byte(it)) items_sent++;
    if (!calm && $urandom_range(0, 99) < 20) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Header byte plus count-1 random bytes, all carrying the same length
  task automatic send_nal(logic [h264_fua_pkg::BYTE_W-1:0] hdr, int unsigned len,
                          int unsigned count);
    send_item(hdr, 1'b1, h264_fua_pkg::NLEN_W'(len));
    for (int unsigned i = 1; i < count; i++) begin
      send_item(h264_fua_pkg::BYTE_W'($urandom), 1'b0, h264_fua_pkg::NLEN_W'(len));
    end
  endtask

  // Stop sending until every expected byte is out, then let the pipe settle
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle
  task automatic cfg_write(h264_fua_pkg::reg_idx_t idx,
                           logic [h264_fua_pkg::CFG_DW-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    sb.set_reg(idx, val);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly short NALs; lengths scale with the payload limit up to 12, else reach 40
  function automatic int unsigned pick_len(int unsigned mp_eff);
    int unsigned top;
    top = (mp_eff <= 12) ? mp_eff * 4 + 2 : 40;
    if ($urandom_range(0, 19) == 0) return 0;
    return $urandom_range(1, top);
  endfunction

  initial begin
    int unsigned                     mp_set[6];
    int unsigned                     ts_set[6];
    int unsigned                     target, kind, len, cut, mp_eff;
    logic [h264_fua_pkg::BYTE_W-1:0] hdr;
    logic [h264_fua_pkg::CFG_DW-1:0] junk_mp, junk_ts;
    bit                              paused;
    sb          = new();
    calm        = 1'b0;
    paused      = 1'b0;
    items_sent  = 0;
    rst_n       <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset settings: SPS/PPS singles, stray byte, zero length
    send_nal(8'h67, 1, 1);
    send_nal(8'h68, 2, 2);
    send_item(8'h00, 1'b0, 16'd5);
    send_item(8'hFF, 1'b1, 16'd0);
    send_nal(8'h65, 3, 3);
    wait_drained();

    // Directed, tiny payload limit
    cfg_write(h264_fua_pkg::REG_MAX_PAYLOAD, 32'd2);
    cfg_write(h264_fua_pkg::REG_TS_STEP, 32'd90000);
    // one fragment with start and end bits
    send_nal(8'hE5, 3, 3);
    // fragmented SPS still advances the timestamp
    send_nal(8'h47, 6, 6);
    // length drops below the byte position at a fragment start
    send_item(8'h41, 1'b1, 16'd9);
    send_item(8'hFF, 1'b0, 16'd9);
    send_item(8'h00, 1'b0, 16'd9);
    send_item(8'h5A, 1'b0, 16'd2);
    // new NAL before the old one ends, with the longest length
    send_item(8'h21, 1'b1, 16'hFFFF);
    send_item(8'hFF, 1'b0, 16'hFFFF);
    send_item(8'h00, 1'b0, 16'hFFFF);
    send_nal(8'h08, 2, 2);
    wait_drained();

    // Random phases over several settings, extremes included
    mp_set = '{1, 0, 5, 1500, 2047, 2};
    ts_set = '{131071, 0, 1, 90000, 3000, 17};
    mp_set[5] = $urandom_range(2, 12);
    ts_set[4] = $urandom_range(0, 131071);
    for (int ph = 0; ph < 6; ph++) begin
      junk_mp = mp_set[ph];
      junk_ts = ts_set[ph];
      if (ph == 4) begin
        junk_mp = junk_mp | 32'hFFFF_F800;
        junk_ts = junk_ts | 32'hFFFE_0000;
      end
      cfg_write(h264_fua_pkg::REG_MAX_PAYLOAD, junk_mp);
      cfg_write(h264_fua_pkg::REG_TS_STEP, junk_ts);
      mp_eff = (mp_set[ph] == 0) ? 1 : mp_set[ph];
      calm   = (ph == 2);
      // full-size fragment followed by a short one
      if (mp_set[ph] == 5) send_nal(8'h7C, 8, 8);
      target = items_sent + 55;
      while (items_sent < target) begin
        if (ph == 5 && !paused && items_sent + 30 >= target) begin
          wait_drained();
          paused = 1'b1;
        end
        kind = $urandom_range(0, 99);
        hdr  = h264_fua_pkg::BYTE_W'($urandom);
        if ($urandom_range(0, 4) == 0) begin
          hdr[4:0] = $urandom_range(0, 1) ? h264_fua_pkg::NAL_TYPE_SPS
                                          : h264_fua_pkg::NAL_TYPE_PPS;
        end
        len = pick_len(mp_eff);
        if (kind < 75) begin
          send_nal(hdr, len, (len == 0) ? 1 : len);
        end else if (kind < 85) begin
          // abandoned by the next header byte
          send_nal(hdr, $urandom_range(8, 65535), $urandom_range(1, 6));
        end else if (kind < 93) begin
          // length shrinks mid-NAL and ends it
          len = $urandom_range(3, 40);
          cut = $urandom_range(1, len - 2);
          send_nal(hdr, len, cut);
          send_item(h264_fua_pkg::BYTE_W'($urandom), 1'b0,
                    h264_fua_pkg::NLEN_W'($urandom_range(0, cut)));
        end else begin
          repeat ($urandom_range(1, 3)) begin
            send_item(h264_fua_pkg::BYTE_W'($urandom), 1'b0,
                      h264_fua_pkg::NLEN_W'($urandom));
          end
        end
      end
      calm = 1'b0;
      wait_drained();
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
